FILE: rtl/core/ipbl_pkg.sv
// Shared types and constants for the IPv4 blocklist table.
package ipbl_pkg;

   localparam int unsigned ENTRIES_DEF = 16;
   localparam int unsigned ADDR_W      = 32;
   localparam int unsigned COUNT_W     = 5;

   typedef enum logic [1:0] {
      CMD_ADD    = 2'd0,
      CMD_DELETE = 2'd1,
      CMD_CHECK  = 2'd2,
      CMD_CLEAR  = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_NOT_FOUND = 2'd1,
      ST_FULL      = 2'd2,
      ST_ZERO      = 2'd3
   } status_type;

   // Broadcast to every cell in the execute cycle.
   typedef struct packed {
      logic              do_add;
      logic              do_del;
      logic              do_clr;
      logic [ADDR_W-1:0] addr;
   } cell_op_type;

   // Handed from one cell to the next along the row.
   typedef struct packed {
      logic free;
      logic hit;
   } chain_type;

endpackage

FILE: rtl/core/ipbl_channels.sv
// Request and response channel interfaces of the IPv4 blocklist table.
interface ipbl_req_if;
   logic                          valid;
   logic                          ready;
   ipbl_pkg::cmd_type             cmd;
   logic [ipbl_pkg::ADDR_W-1:0]   addr;

   modport source (output valid, output cmd, output addr, input ready);
   modport sink   (input valid, input cmd, input addr, output ready);
endinterface

interface ipbl_rsp_if;
   logic                          valid;
   logic                          ready;
   ipbl_pkg::status_type          status;
   logic                          hit;
   logic [ipbl_pkg::COUNT_W-1:0]  entry_count;

   modport source (output valid, output status, output hit, output entry_count, input ready);
   modport sink   (input valid, input status, input hit, input entry_count, output ready);
endinterface

FILE: rtl/core/ipbl_cell.sv
// One table slot: holds an address, compares it and passes free/hit along the row.
module ipbl_cell (
   input  logic                   clock,
   input  logic                   reset,
   input  ipbl_pkg::cell_op_type  op,
   input  ipbl_pkg::chain_type    chain_prev,
   output ipbl_pkg::chain_type    chain_next
);

   logic [ipbl_pkg::ADDR_W-1:0] slot_ff;
   logic [ipbl_pkg::ADDR_W-1:0] slot_in;
   logic                        empty;
   logic                        match;

   assign empty = (slot_ff == '0);
   assign match = (slot_ff == op.addr);

   assign chain_next.free = chain_prev.free | empty;
   assign chain_next.hit  = chain_prev.hit  | match;

   always_comb begin
      slot_in = slot_ff;
      priority if (op.do_clr) begin
         slot_in = '0;
      end else if (op.do_add && empty && !chain_prev.free) begin
         // lowest empty slot claims the address
         slot_in = op.addr;
      end else if (op.do_del && match) begin
         slot_in = '0;
      end else begin
         slot_in = slot_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff <= '0;
      end else begin
         slot_ff <= slot_in;
      end
   end

endmodule

FILE: rtl/core/ipv4_blocklist_table.sv
// IPv4 blocklist table: a row of slot cells compared in parallel.
// An accepted request beat is registered, then executed, and its result is registered.
// Throughput: one beat per cycle unless the reply side stalls; the free/hit
// chain through the row of cells settles within the single execute cycle.
// Reset: synchronous, clears every slot to empty and the count to zero
// with no clearing pass.
module ipv4_blocklist_table #(
   parameter int unsigned ENTRIES = ipbl_pkg::ENTRIES_DEF
) (
   input  logic       clock,
   input  logic       reset,
   ipbl_req_if.sink   req,
   ipbl_rsp_if.source rsp
);

   localparam int unsigned CNT_W = $clog2(ENTRIES + 1);

   logic                        busy_ff;
   logic                        busy_in;
   ipbl_pkg::cmd_type           cmd_ff;
   ipbl_pkg::cmd_type           cmd_in;
   logic [ipbl_pkg::ADDR_W-1:0] addr_ff;
   logic [ipbl_pkg::ADDR_W-1:0] addr_in;
   logic [CNT_W-1:0]            count_ff;
   logic [CNT_W-1:0]            count_in;
   logic                        rsp_valid_ff;
   logic                        rsp_valid_in;
   ipbl_pkg::status_type        status_ff;
   ipbl_pkg::status_type        status_in;
   logic                        hit_ff;
   logic                        hit_in;

   logic                  fire;
   logic                  accept;
   logic                  addr_nz;
   logic                  any_free;
   logic                  any_hit;
   ipbl_pkg::cell_op_type op;
   ipbl_pkg::chain_type   chain [ENTRIES+1];
   logic [CNT_W+ipbl_pkg::COUNT_W-1:0] count_wide;

   // execute when the output register is free or being drained
   assign fire      = busy_ff && (!rsp_valid_ff || rsp.ready);
   assign req.ready = !busy_ff || fire;
   assign accept    = req.valid && req.ready;
   assign addr_nz   = (addr_ff != '0);

   assign op.do_clr = fire && (cmd_ff == ipbl_pkg::CMD_CLEAR);
   assign op.do_add = fire && addr_nz && (cmd_ff == ipbl_pkg::CMD_ADD);
   assign op.do_del = fire && addr_nz && (cmd_ff == ipbl_pkg::CMD_DELETE);
   assign op.addr   = addr_ff;

   assign chain[0] = '{free: 1'b0, hit: 1'b0};

   for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
      ipbl_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .op         (op),
         .chain_prev (chain[i]),
         .chain_next (chain[i+1])
      );
   end

   assign any_free = chain[ENTRIES].free;
   assign any_hit  = chain[ENTRIES].hit;

   always_comb begin
      busy_in      = busy_ff;
      cmd_in       = cmd_ff;
      addr_in      = addr_ff;
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff;
      status_in    = status_ff;
      hit_in       = hit_ff;

      if (rsp_valid_ff && rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (fire) begin
         busy_in      = 1'b0;
         rsp_valid_in = 1'b1;
         hit_in       = 1'b0;
         status_in    = ipbl_pkg::ST_OK;
         if (cmd_ff == ipbl_pkg::CMD_CLEAR) begin
            count_in = '0;
         end else if (!addr_nz) begin
            status_in = ipbl_pkg::ST_ZERO;
         end else begin
            unique case (cmd_ff)
               ipbl_pkg::CMD_ADD: begin
                  if (!any_free) begin
                     status_in = ipbl_pkg::ST_FULL;
                  end else if (count_ff < CNT_W'(ENTRIES)) begin
                     count_in = count_ff + CNT_W'(1);
                  end
               end
               ipbl_pkg::CMD_DELETE: begin
                  if (!any_hit) begin
                     status_in = ipbl_pkg::ST_NOT_FOUND;
                  end else if (count_ff != '0) begin
                     count_in = count_ff - CNT_W'(1);
                  end
               end
               ipbl_pkg::CMD_CHECK: begin
                  hit_in = any_hit;
                  if (!any_hit) begin
                     status_in = ipbl_pkg::ST_NOT_FOUND;
                  end
               end
               default: begin
                  // clear is handled above
                  status_in = ipbl_pkg::ST_OK;
               end
            endcase
         end
      end
      if (accept) begin
         busy_in = 1'b1;
         cmd_in  = req.cmd;
         addr_in = req.addr;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff    <= cmd_in;
      addr_ff   <= addr_in;
      status_ff <= status_in;
      hit_ff    <= hit_in;
   end

   assign count_wide      = {{ipbl_pkg::COUNT_W{1'b0}}, count_ff};
   assign rsp.valid       = rsp_valid_ff;
   assign rsp.status      = status_ff;
   assign rsp.hit         = hit_ff;
   assign rsp.entry_count = count_wide[ipbl_pkg::COUNT_W-1:0];

endmodule

FILE: bench/ipv4_blocklist_table_tb.sv
// Self-checking testbench for the IPv4 blocklist table: corner cases, then random traffic.

typedef struct {
   ipbl_pkg::status_type         status;
   logic                         hit;
   logic [ipbl_pkg::COUNT_W-1:0] entry_count;
} blocklist_reply_type;

class blocklist_scoreboard_type;
   logic [ipbl_pkg::ADDR_W-1:0] slot_addr [ipbl_pkg::ENTRIES_DEF];
   int unsigned                 stored_total;
   blocklist_reply_type         awaited_replies [$];
   int unsigned                 mismatches;
   int unsigned                 replies_seen;
   int unsigned                 hits, misses, full_rejects, zero_rejects, clears;

   function new();
      foreach (slot_addr[i]) slot_addr[i] = '0;
      stored_total = 0;
      mismatches   = 0;
      replies_seen = 0;
      hits         = 0;
      misses       = 0;
      full_rejects = 0;
      zero_rejects = 0;
      clears       = 0;
   endfunction

   // Apply one accepted request beat to the table copy and queue the reply it owes.
   function void note_request(ipbl_pkg::cmd_type cmd, logic [ipbl_pkg::ADDR_W-1:0] addr);
      blocklist_reply_type reply;
      bit                  found;
      reply.status = ipbl_pkg::ST_OK;
      reply.hit    = 1'b0;
      found        = 1'b0;
      if (cmd == ipbl_pkg::CMD_CLEAR) begin
         foreach (slot_addr[i]) slot_addr[i] = '0;
         stored_total = 0;
         clears++;
      end else if (addr == '0) begin
         reply.status = ipbl_pkg::ST_ZERO;
         zero_rejects++;
      end else begin
         case (cmd)
            ipbl_pkg::CMD_ADD: begin
               // lowest empty slot takes it; copies already present are not looked for
               foreach (slot_addr[i]) begin
                  if (!found && slot_addr[i] == '0) begin
                     slot_addr[i] = addr;
                     found        = 1'b1;
                  end
               end
               if (!found) begin
                  reply.status = ipbl_pkg::ST_FULL;
                  full_rejects++;
               end else if (stored_total < ipbl_pkg::ENTRIES_DEF) begin
                  stored_total++;
               end
            end
            ipbl_pkg::CMD_DELETE: begin
               foreach (slot_addr[i]) begin
                  if (slot_addr[i] == addr) begin
                     slot_addr[i] = '0;
                     found        = 1'b1;
                  end
               end
               // count down once, however many copies went
               if (found) begin
                  if (stored_total > 0) stored_total--;
               end else begin
                  reply.status = ipbl_pkg::ST_NOT_FOUND;
                  misses++;
               end
            end
            default: begin
               foreach (slot_addr[i]) begin
                  if (slot_addr[i] == addr) found = 1'b1;
               end
               if (found) begin
                  reply.hit = 1'b1;
                  hits++;
               end else begin
                  reply.status = ipbl_pkg::ST_NOT_FOUND;
                  misses++;
               end
            end
         endcase
      end
      reply.entry_count = ipbl_pkg::COUNT_W'(stored_total);
      awaited_replies.push_back(reply);
   endfunction

   task report_mismatch(string what);
      mismatches++;
      if (mismatches <= 40) $display("[%0t] mismatch at reply %0d: %s", $time, replies_seen, what);
   endtask

   task check_reply(ipbl_pkg::status_type status, logic hit,
                    logic [ipbl_pkg::COUNT_W-1:0] count);
      blocklist_reply_type want;
      replies_seen++;
      if (awaited_replies.size() == 0) begin
         report_mismatch($sformatf("reply beat with no request outstanding (status %0d)", status));
      end else begin
         want = awaited_replies.pop_front();
         if (status !== want.status)
            report_mismatch($sformatf("status %0d, want %0d", status, want.status));
         if (hit !== want.hit)
            report_mismatch($sformatf("hit %b, want %b", hit, want.hit));
         if (count !== want.entry_count)
            report_mismatch($sformatf("entry_count %0d, want %0d", count, want.entry_count));
      end
   endtask
endclass

module ipv4_blocklist_table_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned CYCLE_LIMIT   = 200_000;
   localparam int unsigned POOL_SIZE     = 24;
   localparam int unsigned PHASE_ITEMS   = 420;
   localparam int unsigned PRESSURE_BEATS = 60;
   localparam int unsigned HOLD_CYCLES   = 150;
   localparam int unsigned SETTLE_CYCLES = 5;

   logic                        clock = 1'b0;
   logic                        reset;
   logic                        hold_rsp;
   int unsigned                 send_idle_pct = 0;
   int unsigned                 recv_idle_pct = 0;
   int unsigned                 add_share     = 400;
   int unsigned                 items_sent    = 0;
   int unsigned                 cycle_count   = 0;
   logic [ipbl_pkg::ADDR_W-1:0] addr_pool [POOL_SIZE];
   blocklist_scoreboard_type    sb = new();

   ipbl_req_if req_ch();
   ipbl_rsp_if rsp_ch();

   ipv4_blocklist_table u_dut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Reply side: random stalls, or a long hold-off while hold_rsp is up.
   always @(posedge clock) begin
      if (hold_rsp) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_ch.valid && req_ch.ready) sb.note_request(req_ch.cmd, req_ch.addr);
         if (rsp_ch.valid && rsp_ch.ready)
            sb.check_reply(rsp_ch.status, rsp_ch.hit, rsp_ch.entry_count);
      end
   end

   task automatic send_item(ipbl_pkg::cmd_type cmd, logic [ipbl_pkg::ADDR_W-1:0] addr);
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.cmd   <= cmd;
      req_ch.addr  <= addr;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      items_sent++;
   endtask

   task automatic send_random_item();
      int unsigned                 pick;
      ipbl_pkg::cmd_type           cmd;
      logic [ipbl_pkg::ADDR_W-1:0] addr;
      pick = $urandom_range(999);
      if (pick < 15) begin
         cmd = ipbl_pkg::CMD_CLEAR;
      end else if (pick < 15 + add_share) begin
         cmd = ipbl_pkg::CMD_ADD;
      end else if (pick[0]) begin
         cmd = ipbl_pkg::CMD_DELETE;
      end else begin
         cmd = ipbl_pkg::CMD_CHECK;
      end
      // mostly pool addresses so that hits, duplicates and a full table turn up
      case ($urandom_range(9))
         0:             addr = '0;
         1, 2, 3, 4, 5, 6: addr = addr_pool[$urandom_range(POOL_SIZE - 1)];
         default:       addr = $urandom;
      endcase
      send_item(cmd, addr);
   endtask

   // Hold the request side low until every reply owed has come back.
   task automatic wait_drained();
      req_ch.valid <= 1'b0;
      while (sb.replies_seen < items_sent) @(posedge clock);
   endtask

   task automatic run_directed();
      send_item(ipbl_pkg::CMD_CHECK, 32'h0A00_0001);
      send_item(ipbl_pkg::CMD_ADD, '0);
      send_item(ipbl_pkg::CMD_DELETE, '0);
      send_item(ipbl_pkg::CMD_ADD, 32'hFFFF_FFFF);
      send_item(ipbl_pkg::CMD_ADD, 32'h0000_0001);
      send_item(ipbl_pkg::CMD_ADD, 32'h8000_0000);
      // duplicate takes a second slot
      send_item(ipbl_pkg::CMD_ADD, 32'h0000_0001);
      send_item(ipbl_pkg::CMD_CHECK, 32'hFFFF_FFFF);
      // both copies go, count drops by one only
      send_item(ipbl_pkg::CMD_DELETE, 32'h0000_0001);
      // fill every slot; the count saturates on the last add
      repeat (14) send_item(ipbl_pkg::CMD_ADD, $urandom | 32'h1);
      send_item(ipbl_pkg::CMD_ADD, 32'h5555_AAAA);
      send_item(ipbl_pkg::CMD_CLEAR, 32'hDEAD_BEEF);
   endtask

   initial begin
      int unsigned phase;
      reset        <= 1'b1;
      hold_rsp     <= 1'b0;
      req_ch.valid <= 1'b0;
      req_ch.cmd   <= ipbl_pkg::CMD_ADD;
      req_ch.addr  <= '0;
      foreach (addr_pool[i]) addr_pool[i] = $urandom;
      addr_pool[0] = 32'hFFFF_FFFF;
      addr_pool[1] = 32'h0000_0001;
      addr_pool[2] = 32'h8000_0000;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      run_directed();
      wait_drained();

      for (phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin
               send_idle_pct = 20;
               recv_idle_pct = 86;
               add_share     = 520;
            end
            1: begin
               send_idle_pct = 86;
               recv_idle_pct = 20;
               add_share     = 400;
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
               add_share     = 340;
            end
         endcase
         if (phase == 2) begin
            // stall the reply side while requests keep coming, so the block backs up
            fork
               begin
                  hold_rsp <= 1'b1;
                  repeat (HOLD_CYCLES) @(posedge clock);
                  hold_rsp <= 1'b0;
               end
               repeat (PRESSURE_BEATS) send_random_item();
            join
         end
         repeat (PHASE_ITEMS) send_random_item();
         wait_drained();
      end

      repeat (SETTLE_CYCLES) @(posedge clock);
      if (sb.awaited_replies.size() != 0)
         sb.report_mismatch($sformatf("%0d replies never arrived", sb.awaited_replies.size()));

      $display("Ran %0d requests in %0d cycles: %0d hits, %0d misses, %0d full, %0d zero, %0d clears",
               items_sent, cycle_count, sb.hits, sb.misses, sb.full_rejects,
               sb.zero_rejects, sb.clears);
      $display("Checked %0d replies under three stall patterns and a long hold-off, %0d mismatches",
               sb.replies_seen, sb.mismatches);
      if (sb.mismatches == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Timed out after %0d cycles, %0d of %0d replies seen",
               cycle_count, sb.replies_seen, items_sent);
      $display("*** FAILED ***");
      $finish;
   end

endmodule
